### design/qdc_pkg.sv
package qdc_pkg;

  // Word type nibble, bits 15..12 of the high half
  localparam logic [3:0] WORD_HEADER = 4'h4;
  localparam logic [3:0] WORD_DATA   = 4'h0;

  // Module id reported once an event is marked invalid
  localparam logic [7:0] INVALID_ID = 8'd99;

  // Register map, index = byte address / 4
  localparam int unsigned NUM_ID_REGS = 4;
  localparam logic [2:0] REG_ID_A   = 3'd0;
  localparam logic [2:0] REG_ID_B   = 3'd1;
  localparam logic [2:0] REG_ID_C   = 3'd2;
  localparam logic [2:0] REG_ID_D   = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;

  // Parser phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_DATA    = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [4:0]  channel;
    logic [11:0] conversion;
    logic [7:0]  module_id;
    logic        event_accepted;
    logic        end_of_event;
  } result_t;

endpackage

### design/qdc_front.sv
module qdc_front
  import qdc_pkg::*;
#(
  parameter int unsigned NUM_IDS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             word_low,
  input  logic [15:0]             word_high,
  input  logic [NUM_IDS-1:0][7:0] slot_id,
  input  logic [NUM_IDS-1:0]      slot_en,
  input  logic                    queue_full,
  output logic                    push,
  output result_t                 push_data
);

  logic [1:0]  phase, phase_next;
  logic [11:0] words_left, words_left_next;
  logic [7:0]  current_id, current_id_next;
  logic        accepted, accepted_next;

  logic        in_fire;
  logic        hdr_ok;
  logic        data_ok;
  logic [11:0] count;
  logic [7:0]  id_sel;
  logic        id_match;

  assign in_ready = ~queue_full;
  assign in_fire  = in_valid & in_ready;
  assign hdr_ok   = (word_high[15:12] == WORD_HEADER);
  assign data_ok  = (word_high[15:12] == WORD_DATA);
  assign count    = word_low[11:0];
  assign id_sel   = hdr_ok ? word_high[7:0] : INVALID_ID;

  always_comb begin
    id_match = 1'b0;
    for (int i = 0; i < NUM_IDS; i++) begin
      if (slot_en[i] && (slot_id[i] == id_sel)) begin
        id_match = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    words_left_next = words_left;
    current_id_next = current_id;
    accepted_next   = accepted;
    push            = 1'b0;
    push_data       = '0;
    unique case (phase)
      PH_DATA: begin
        words_left_next = words_left - 12'd1;
        if (words_left_next == 12'd0) begin
          phase_next = PH_TRAILER;
        end
        if (accepted) begin
          push                     = in_fire;
          push_data.event_accepted = 1'b1;
          if (data_ok) begin
            push_data.channel    = word_high[4:0];
            push_data.conversion = word_low[11:0];
            push_data.module_id  = current_id;
          end else begin
            current_id_next     = INVALID_ID;
            push_data.module_id = INVALID_ID;
          end
        end
      end
      PH_TRAILER: begin
        phase_next                = PH_HEADER;
        words_left_next           = 12'd0;
        push                      = in_fire;
        push_data.module_id       = current_id;
        push_data.event_accepted  = accepted;
        push_data.end_of_event    = 1'b1;
      end
      default: begin
        // header expected; the spare phase code lands here too
        current_id_next = id_sel;
        accepted_next   = id_match;
        if (hdr_ok) begin
          words_left_next = (count > 12'd1) ? count - 12'd1 : 12'd0;
          phase_next      = (count > 12'd1) ? PH_DATA : PH_TRAILER;
        end else begin
          words_left_next          = 12'd0;
          phase_next               = PH_TRAILER;
          push                     = in_fire;
          push_data.module_id      = INVALID_ID;
          push_data.event_accepted = id_match;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      words_left <= 12'd0;
      current_id <= 8'd0;
      accepted   <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      words_left <= words_left_next;
      current_id <= current_id_next;
      accepted   <= accepted_next;
    end
  end

  a_last_data_to_trailer: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_DATA && words_left == 12'd1 |=> phase == PH_TRAILER)
    else $error("last data beat did not move to trailer");

  a_trailer_to_header: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_TRAILER |=> phase == PH_HEADER && words_left == 12'd0)
    else $error("trailer did not close the event");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> in_fire)
    else $error("result pushed without an input beat");

  a_data_has_words: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> words_left != 12'd0)
    else $error("data phase with no words left");

endmodule

### design/qdc_queue.sv
module qdc_queue
  import qdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign full      = (count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    FIFO_AW'(wr_ptr - rd_ptr) == count[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

### design/qdc_event_word_unpacker_core.sv
// Event word unpacker: header / data / trailer readout words in, results out.
// Throughput: one input beat per cycle, sustained, while the output side keeps up.
// Each result is queued as its input beat is taken and offered on m_tvalid in queue order.
// Result queue holds 4 entries; s_tready drops only when it is full.
// Reset (rst, synchronous): parser back to header, queue emptied, registers cleared.
module qdc_event_word_unpacker_core
  import qdc_pkg::*;
#(
  parameter int unsigned NUM_IDS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] word_low, [31:16] word_high
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] channel, [16:5] conversion, [24:17] module_id, 0 above
  output logic        m_tuser,   // [0] event_accepted
  output logic        m_tlast,   // end_of_event
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [7:0] id_reg [NUM_ID_REGS];
  logic [3:0] id_enable_mask;
  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ID_REGS; i++) begin
        id_reg[i] <= 8'd0;
      end
      id_enable_mask <= 4'd0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ID_A:   id_reg[0]      <= pwdata[7:0];
        REG_ID_B:   id_reg[1]      <= pwdata[7:0];
        REG_ID_C:   id_reg[2]      <= pwdata[7:0];
        REG_ID_D:   id_reg[3]      <= pwdata[7:0];
        REG_ENABLE: id_enable_mask <= pwdata[3:0];
        default:    ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ID_A:   prdata = {24'd0, id_reg[0]};
      REG_ID_B:   prdata = {24'd0, id_reg[1]};
      REG_ID_C:   prdata = {24'd0, id_reg[2]};
      REG_ID_D:   prdata = {24'd0, id_reg[3]};
      REG_ENABLE: prdata = {28'd0, id_enable_mask};
      default:    prdata = 32'd0;
    endcase
  end

  // Id slots for matching; slots past the register file read 0 and stay off
  logic [NUM_IDS-1:0][7:0] slot_id;
  logic [NUM_IDS-1:0]      slot_en;

  for (genvar g = 0; g < NUM_IDS; g++) begin : g_slot
    if (g < NUM_ID_REGS) begin : g_reg
      assign slot_id[g] = id_reg[g];
      assign slot_en[g] = id_enable_mask[g];
    end else begin : g_off
      assign slot_id[g] = 8'd0;
      assign slot_en[g] = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Front: takes each beat, tracks the event and builds its result
  // ---------------------------------------------------------------
  logic    queue_full;
  logic    push;
  result_t push_data;

  qdc_front #(
    .NUM_IDS (NUM_IDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .word_low   (s_tdata[15:0]),
    .word_high  (s_tdata[31:16]),
    .slot_id    (slot_id),
    .slot_en    (slot_en),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // ---------------------------------------------------------------
  // Back: result queue feeding the output stream
  // ---------------------------------------------------------------
  result_t out_data;

  qdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {7'd0, out_data.module_id, out_data.conversion, out_data.channel};
  assign m_tuser = out_data.event_accepted;
  assign m_tlast = out_data.end_of_event;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

// Event word unpacker bench.
// Drives readout words (header / data / trailer) into the stream input,
// predicts each result beat from a behavioral tracker of the parser or a
// typed directed row, and checks the output stream field by field in order.
// Module id registers are written over APB only while the block is drained.
module tb;
  import qdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned BEATS_PER_PHASE = 320;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qdc_event_word_unpacker_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] word_low, [31:16] word_high
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [4:0] channel, [16:5] conversion, [24:17] module_id
    .m_tuser  (m_tuser),   // [0] event_accepted
    .m_tlast  (m_tlast),   // end_of_event
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the id registers and of the parser state
  logic [7:0]  acc_ids [NUM_ID_REGS];
  logic [3:0]  id_en;
  logic [1:0]  trk_phase;
  logic [11:0] trk_left;
  logic [7:0]  trk_id;
  logic        trk_acc;

  result_t     pending_results[$];
  int unsigned fails;
  int unsigned cycles;
  int unsigned words_sent;

  // Idle odds in percent, per side
  int unsigned src_idle;
  int unsigned sink_idle;

  // Directed rows may carry a hand-typed expectation for the beat in flight
  bit          beat_typed;
  bit          beat_has;
  result_t     beat_res;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    bit          has;
    result_t     res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // True when an enabled id slot holds this id
  function automatic logic id_hit(input logic [7:0] id);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_ID_REGS; i++)
      if (id_en[i] && acc_ids[i] == id) hit = 1'b1;
    return hit;
  endfunction

  // Advance the tracked parser by one word; emit tells whether a result comes out
  task automatic unpack_word(input logic [31:0] w, output bit emit, output result_t r);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = w[15:0];
    hi = w[31:16];
    emit = 1'b0;
    r = '0;
    if (trk_phase == PH_DATA) begin
      if (trk_acc) begin
        emit = 1'b1;
        if (hi[15:12] == WORD_DATA) begin
          r.channel    = hi[4:0];
          r.conversion = lo[11:0];
        end else begin
          // non-data word poisons the rest of the event
          trk_id = INVALID_ID;
        end
      end
      trk_left = trk_left - 12'd1;
      if (trk_left == 12'd0) trk_phase = PH_TRAILER;
    end else if (trk_phase == PH_TRAILER) begin
      emit = 1'b1;
      r.end_of_event = 1'b1;
      trk_phase = PH_HEADER;
      trk_left = '0;
    end else if (hi[15:12] == WORD_HEADER) begin
      trk_id = hi[7:0];
      trk_acc = id_hit(trk_id);
      // count includes the trailer; 0 and 1 both mean no data words
      trk_left = (lo[11:0] > 12'd1) ? lo[11:0] - 12'd1 : 12'd0;
      trk_phase = (trk_left != 12'd0) ? PH_DATA : PH_TRAILER;
    end else begin
      // bad header: one error datum, then straight to trailer
      trk_id = INVALID_ID;
      trk_acc = id_hit(trk_id);
      trk_left = '0;
      trk_phase = PH_TRAILER;
      emit = 1'b1;
    end
    if (emit) begin
      r.module_id = trk_id;
      r.event_accepted = trk_acc;
    end
  endtask

  // Cycle count, timeout, input-beat prediction and output-beat checks
  always @(posedge clk) begin : monitor
    bit      emit;
    result_t pred;
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[qdc_event_word_unpacker_core] ERROR");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      unpack_word(s_tdata, emit, pred);
      if (beat_typed) begin
        emit = beat_has;
        pred = beat_res;
      end
      if (emit) pending_results = {pending_results, pred};
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %08h", m_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[4:0] !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, m_tdata[4:0]);
          fails++;
        end
        if (m_tdata[16:5] !== want.conversion) begin
          $error("conversion: expected %0d, got %0d", want.conversion, m_tdata[16:5]);
          fails++;
        end
        if (m_tdata[24:17] !== want.module_id) begin
          $error("module_id: expected %0d, got %0d", want.module_id, m_tdata[24:17]);
          fails++;
        end
        if (m_tuser !== want.event_accepted) begin
          $error("event_accepted: expected %0d, got %0d", want.event_accepted, m_tuser);
          fails++;
        end
        if (m_tlast !== want.end_of_event) begin
          $error("end_of_event: expected %0d, got %0d", want.end_of_event, m_tlast);
          fails++;
        end
        if (m_tdata[31:25] !== 7'd0) begin
          $error("tdata padding: expected 0, got %0h", m_tdata[31:25]);
          fails++;
        end
      end
    end
  end

  // Receiver stalls at random
  always @(negedge clk)
    m_tready <= ($urandom_range(0, 99) >= sink_idle);

  // One input beat; returns once it has been taken
  task automatic send_word(input logic [31:0] w, input bit typed, input bit has,
                           input result_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    beat_typed = typed;
    beat_has = has;
    beat_res = r;
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending and wait until every predicted beat is out, then let the
  // clock run on in case the last word produced nothing
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    beat_typed = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write then read back the same register
  task automatic program_reg(input logic [2:0] idx, input logic [7:0] val);
    logic [31:0] want;
    want = (idx == REG_ENABLE) ? {28'd0, val[3:0]} : {24'd0, val};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_ENABLE) id_en = val[3:0];
    else acc_ids[idx[1:0]] = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata reg %0d: expected %0h, got %0h", idx, want, prdata);
      fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ids(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                         input logic [7:0] d, input logic [3:0] mask);
    wait_drained();
    program_reg(REG_ID_A, a);
    program_reg(REG_ID_B, b);
    program_reg(REG_ID_C, c);
    program_reg(REG_ID_D, d);
    program_reg(REG_ENABLE, {4'd0, mask});
  endtask

  task automatic add_row(input logic [31:0] w, input bit typed, input bit has,
                         input logic [4:0] ch, input logic [11:0] conv,
                         input logic [7:0] id, input logic acc, input logic eoe);
    dir_row_t row;
    row.word = w;
    row.typed = typed;
    row.has = has;
    row.res.channel = ch;
    row.res.conversion = conv;
    row.res.module_id = id;
    row.res.event_accepted = acc;
    row.res.end_of_event = eoe;
    dir_rows = {dir_rows, row};
  endtask

  // One random event: mostly well-formed with random content, some bad
  // headers and some non-data words inside the data run
  task automatic send_event(input logic [11:0] force_count);
    logic [31:0] r;
    logic [7:0]  id;
    logic [11:0] n;
    int unsigned sel;
    if (force_count == 12'd0 && $urandom_range(0, 99) < 10) begin
      r = $urandom;
      if (r[31:28] == WORD_HEADER) r[31:28] = ~WORD_HEADER;
      send_word(r, 1'b0, 1'b0, '0);
      send_word($urandom, 1'b0, 1'b0, '0);
    end else begin
      sel = $urandom_range(0, 5);
      if (sel < NUM_ID_REGS) id = acc_ids[sel[1:0]];
      else if (sel == 4) id = INVALID_ID;
      else id = 8'($urandom);
      if (force_count != 12'd0) n = force_count;
      else if ($urandom_range(0, 9) == 0) n = 12'($urandom_range(9, 40));
      else n = 12'($urandom_range(0, 8));
      r = $urandom;
      send_word({WORD_HEADER, r[27:24], id, r[15:12], n}, 1'b0, 1'b0, '0);
      for (int k = 1; k < n; k++) begin
        r = $urandom;
        if ($urandom_range(0, 99) < 6) r[31:28] = 4'($urandom_range(1, 15));
        else r[31:28] = WORD_DATA;
        send_word(r, 1'b0, 1'b0, '0);
      end
      // trailer word content is never checked by the block
      send_word($urandom, 1'b0, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [7:0] ids [4];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fails = 0;
    cycles = 0;
    words_sent = 0;
    src_idle = 33;
    sink_idle = 81;
    beat_typed = 1'b0;
    beat_has = 1'b0;
    beat_res = '0;
    for (int i = 0; i < NUM_ID_REGS; i++) acc_ids[i] = '0;
    id_en = '0;
    trk_phase = PH_HEADER;
    trk_left = '0;
    trk_id = '0;
    trk_acc = 1'b0;

    // Directed table.  Rows 0-1 run on reset registers; the rest run with
    // ids 0x12, 0x00, 0xff and the invalid id, all enabled.
    // bad header straight out of reset: nothing enabled, so not accepted
    add_row(32'h0000_0000, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b0, 1'b1);
    // accepted event, two data words at the field extremes
    add_row(32'h4012_0003, 1, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h001F_0FFF, 1, 1, 5'd31, 12'd4095, 8'h12, 1'b1, 1'b0);
    add_row(32'h0000_0000, 1, 1, 5'd0, 12'd0, 8'h12, 1'b1, 1'b0);
    add_row(32'h0000_0000, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    // count of zero, then of one: trailer follows directly
    add_row(32'h40FF_0000, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h4000_0001, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h4000_0001, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    // rejected event: data and even a non-data word go by silently
    add_row(32'h4055_0003, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h0003_0456, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'hF000_0000, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h0000_0000, 1, 1, 5'd0, 12'd0, 8'h55, 1'b0, 1'b1);
    // non-data word in an accepted event marks the rest invalid
    add_row(32'h4012_0003, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'hF000_0ABC, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b1, 1'b0);
    add_row(32'h0005_0123, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h0000_0000, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b1, 1'b1);
    // bad header whose invalid id is itself enabled
    add_row(32'hF0AB_1234, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b1, 1'b0);
    add_row(32'h0000_0000, 1, 1, 5'd0, 12'd0, INVALID_ID, 1'b1, 1'b1);
    // junk above the 12-bit count and conversion fields
    add_row(32'h4012_F002, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h0FFF_F000, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);
    add_row(32'h8000_0000, 0, 0, 5'd0, 12'd0, 8'd0, 1'b0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == 2) set_ids(8'h12, 8'h00, 8'hFF, INVALID_ID, 4'hF);
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res);
    end

    // Random phases: idle pattern changes every two phases, registers every phase
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          src_idle = 33;
          sink_idle = 81;
        end
        1: begin
          src_idle = 81;
          sink_idle = 33;
        end
        default: begin
          src_idle = 0;
          sink_idle = 0;
        end
      endcase
      for (int i = 0; i < 4; i++)
        ids[i] = ($urandom_range(0, 4) == 0) ? INVALID_ID : 8'($urandom);
      if (ph == 0) set_ids(8'h00, 8'h00, 8'h00, 8'h00, 4'h0);
      else if (ph == 1) set_ids(8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF);
      else if (ph == 5) set_ids(ids[0], ids[1], ids[2], ids[3], 4'hF);
      else set_ids(ids[0], ids[1], ids[2], ids[3], 4'($urandom_range(0, 15)));
      words_sent = 0;
      // one long event, at full rate
      if (ph == 5) send_event(12'd200);
      while (words_sent < BEATS_PER_PHASE) begin
        // now and then hold off until the output side has caught up
        if ($urandom_range(0, 99) < 3) wait_drained();
        send_event(12'd0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails == 0)
      $display("[qdc_event_word_unpacker_core] OK");
    else
      $display("[qdc_event_word_unpacker_core] ERROR");
    $finish;
  end

endmodule

### sim.f
design/qdc_pkg.sv
design/qdc_front.sv
design/qdc_queue.sv
design/qdc_event_word_unpacker_core.sv
verif/tb.sv
